/* sv/ashp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ashp_pkg
// Types and constants shared by the allocation size histogram profiler.
// ----------------------------------------------------------------------------
package ashp_pkg;

	localparam int unsigned BINS_DEFAULT = 4096;

	typedef enum logic [1:0] {
		REQ_LOG         = 2'd0,
		REQ_READ_COUNT  = 2'd1,
		REQ_READ_TOTALS = 2'd2,
		REQ_RESERVED    = 2'd3
	} req_type_t;

	typedef struct packed {
		req_type_t   req_type;
		logic        is_alloc;
		logic        is_realloc;
		logic        is_zero_init;
		logic        succeeded;
		logic [31:0] byte_count;
		logic [2:0]  read_table;
		logic [12:0] read_bin;
	} req_t;

	typedef struct packed {
		logic [31:0] count_value;
		logic [63:0] allocated_total;
		logic [63:0] zero_init_total;
		logic [63:0] freed_total;
		logic        totals_valid;
	} rsp_t;

endpackage

/* sv/alloc_size_histogram_profiler_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alloc_size_histogram_profiler_core
// Eight histograms of wrapping 32-bit counters plus three 64-bit byte totals.
// ----------------------------------------------------------------------------
// Takes one transaction per clock, except while clearing or while a read
// result waits on a full output register that is not taken. Log events,
// counter reads and totals reads all pass through one read-modify-write
// stage on a single-port-write counter memory with a registered read;
// back-to-back hits on the same counter are served by forwarding the value
// being written. After reset the counter memory is cleared one entry per
// cycle, 8 * (BINS + 1) entries (32776 at the default BINS), during which no
// request is taken; configuration writes are taken at any time.
// Table index is success*4 + realloc*2 + alloc; bin BINS is the overflow bin.
module alloc_size_histogram_profiler_core
	import ashp_pkg::*;
#(
	parameter int unsigned BINS = BINS_DEFAULT
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  req_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output rsp_t out_data,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic cfg_data
);

	localparam int unsigned DEPTH  = 8 * (BINS + 1);
	localparam int unsigned ADDR_W = $clog2(DEPTH);
	localparam int unsigned BIN_W  = $clog2(BINS + 1);
	localparam logic [ADDR_W-1:0] SPAN      = ADDR_W'(BINS + 1);
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
	localparam logic [31:0]       BINS_32   = 32'(BINS);

	logic [31:0] mem [DEPTH];

	logic              enabled_q;
	logic              clr_q;
	logic [ADDR_W-1:0] clr_addr_q;

	logic              valid_s1;
	req_t              req_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic              bin_ok_s1;
	logic              fwd_s1;
	logic [31:0]       fwd_data_s1;
	logic [31:0]       rd_q;

	logic [63:0] alloc_q;
	logic [63:0] zinit_q;
	logic [63:0] freed_q;

	logic        out_valid_q;
	rsp_t        out_q;

	// input side address
	logic [31:0]       in_bin_w;
	logic [BIN_W-1:0]  in_bin;
	logic              in_bin_ok;
	logic [2:0]        in_table;
	logic [ADDR_W-1:0] in_addr;
	logic              take;

	// stage 1
	logic        result_s1;
	logic        stall_s1;
	logic        log_we;
	logic [31:0] cnt_s1;
	logic [31:0] inc_s1;
	logic [63:0] size_s1;
	rsp_t        rsp_s1;

	logic              mem_we;
	logic [ADDR_W-1:0] mem_wa;
	logic [31:0]       mem_wd;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q <= 1'b0;
		end else if (cfg_valid) begin
			enabled_q <= cfg_data;
		end
	end

	// bin and table selection for the incoming transaction
	always_comb begin
		in_bin_w  = 32'd0;
		in_bin_ok = 1'b1;
		in_table  = in_data.read_table;
		unique case (in_data.req_type)
			REQ_LOG: begin
				in_table = {in_data.succeeded, in_data.is_realloc, in_data.is_alloc};
				in_bin_w = (in_data.byte_count < BINS_32) ? in_data.byte_count : BINS_32;
			end
			REQ_READ_COUNT: begin
				in_bin_w  = 32'(in_data.read_bin);
				in_bin_ok = (32'(in_data.read_bin) <= BINS_32);
			end
			default: begin
				in_bin_w = 32'd0;
			end
		endcase
		in_bin  = in_bin_w[BIN_W-1:0];
		in_addr = in_bin_ok ? (ADDR_W'(in_table) * SPAN + ADDR_W'(in_bin)) : '0;
	end

	assign result_s1 = valid_s1 && (req_s1.req_type == REQ_READ_COUNT ||
		req_s1.req_type == REQ_READ_TOTALS);
	assign stall_s1  = result_s1 && out_valid_q && !out_ready;
	assign in_ready  = !clr_q && !stall_s1;
	assign take      = in_valid && in_ready;

	assign cnt_s1  = fwd_s1 ? fwd_data_s1 : rd_q;
	assign inc_s1  = cnt_s1 + 32'd1;
	assign size_s1 = {32'd0, req_s1.byte_count};
	assign log_we  = valid_s1 && (req_s1.req_type == REQ_LOG) && enabled_q;

	assign mem_we = clr_q || log_we;
	assign mem_wa = clr_q ? clr_addr_q : addr_s1;
	assign mem_wd = clr_q ? 32'd0 : inc_s1;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (take) begin
			rd_q <= mem[in_addr];
		end
	end

	// clearing pass after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + ADDR_W'(1);
			if (clr_addr_q == LAST_ADDR) begin
				clr_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (!stall_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// same-counter hazard: the memory read misses the write on this edge
	always_ff @(posedge clk) begin
		if (take) begin
			req_s1      <= in_data;
			addr_s1     <= in_addr;
			bin_ok_s1   <= in_bin_ok;
			fwd_s1      <= log_we && (addr_s1 == in_addr);
			fwd_data_s1 <= inc_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alloc_q <= '0;
			zinit_q <= '0;
			freed_q <= '0;
		end else if (log_we && req_s1.succeeded) begin
			if (req_s1.is_alloc) begin
				alloc_q <= alloc_q + size_s1;
				if (req_s1.is_zero_init) begin
					zinit_q <= zinit_q + size_s1;
				end
			end else begin
				freed_q <= freed_q + size_s1;
			end
		end
	end

	always_comb begin
		rsp_s1 = '0;
		if (req_s1.req_type == REQ_READ_COUNT) begin
			rsp_s1.count_value = bin_ok_s1 ? cnt_s1 : 32'd0;
		end else if (enabled_q) begin
			rsp_s1.allocated_total = alloc_q;
			rsp_s1.zero_init_total = zinit_q;
			rsp_s1.freed_total     = freed_q;
			rsp_s1.totals_valid    = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (result_s1 && !stall_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (result_s1 && !stall_s1) begin
			out_q <= rsp_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

/* dv/tb_alloc_size_histogram_profiler_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_alloc_size_histogram_profiler_core
// Self-checking bench for the allocation size histogram profiler.
// ----------------------------------------------------------------------------
// Drives log events, counter reads and totals reads through the request
// channel with random gaps and output back-pressure. A scoreboard class keeps
// its own histograms and byte totals, predicts each read result when the
// request is taken, and checks every response field by field in order.
// Profiling is switched on and off between phases while the core is idle.
module tb_alloc_size_histogram_profiler_core;
	import ashp_pkg::*;

	localparam int BINS         = BINS_DEFAULT;
	localparam int DRAIN_CYCLES = 8;
	localparam int LONG_HOLD    = 300;
	localparam int CYCLE_LIMIT  = 500000;

	class profiler_scoreboard;
		bit [31:0] hist_count [8][BINS + 1];
		bit [63:0] bytes_allocated;
		bit [63:0] bytes_zero_init;
		bit [63:0] bytes_freed;
		bit        enabled;
		rsp_t      pending_reads[$];
		int        errors;

		function new();
			foreach (hist_count[t, b])
				hist_count[t][b] = '0;
			bytes_allocated = '0;
			bytes_zero_init = '0;
			bytes_freed     = '0;
			enabled         = 1'b0;
			errors          = 0;
		endfunction

		// Updates the histograms and totals, queues the result if one is due.
		function void note_request(req_t r);
			rsp_t rsp;
			int   bin;
			rsp = '0;
			case (r.req_type)
				REQ_LOG: begin
					if (enabled) begin
						bin = (r.byte_count < BINS) ? int'(r.byte_count) : BINS;
						hist_count[{r.succeeded, r.is_realloc, r.is_alloc}][bin] += 1;
						if (r.succeeded) begin
							if (r.is_alloc) begin
								bytes_allocated += 64'(r.byte_count);
								if (r.is_zero_init)
									bytes_zero_init += 64'(r.byte_count);
							end else begin
								bytes_freed += 64'(r.byte_count);
							end
						end
					end
				end
				REQ_READ_COUNT: begin
					if (r.read_bin <= BINS)
						rsp.count_value = hist_count[r.read_table][r.read_bin];
					pending_reads.push_back(rsp);
				end
				REQ_READ_TOTALS: begin
					if (enabled) begin
						rsp.allocated_total = bytes_allocated;
						rsp.zero_init_total = bytes_zero_init;
						rsp.freed_total     = bytes_freed;
						rsp.totals_valid    = 1'b1;
					end
					pending_reads.push_back(rsp);
				end
				default: ;
			endcase
		endfunction

		function void compare_field(string name, logic [63:0] want, logic [63:0] got);
			if (got !== want) begin
				$error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
				errors++;
			end
		endfunction

		function void check_response(rsp_t got);
			rsp_t want;
			if (pending_reads.size() == 0) begin
				$error("response with no read outstanding: 0x%0h", got);
				errors++;
				return;
			end
			want = pending_reads.pop_front();
			compare_field("count_value", 64'(want.count_value), 64'(got.count_value));
			compare_field("allocated_total", want.allocated_total, got.allocated_total);
			compare_field("zero_init_total", want.zero_init_total, got.zero_init_total);
			compare_field("freed_total", want.freed_total, got.freed_total);
			compare_field("totals_valid", 64'(want.totals_valid), 64'(got.totals_valid));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	req_t in_data;
	logic out_valid;
	logic out_ready;
	rsp_t out_data;
	logic cfg_valid;
	logic cfg_ready;
	logic cfg_data;

	profiler_scoreboard sb = new();
	bit steady;
	bit long_hold_req;
	int cycles;

	alloc_size_histogram_profiler_core #(.BINS(BINS)) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [31:0] pick_size();
		int k;
		k = $urandom_range(0, 99);
		if (k < 50)
			return $urandom_range(0, 15);
		if (k < 70)
			return $urandom_range(BINS - 3, BINS + 3);
		if (k < 85)
			return $urandom_range(0, BINS - 1);
		return $urandom;
	endfunction

	// reads aim mostly at the bins that the log events hit
	function automatic logic [12:0] pick_bin();
		int k;
		k = $urandom_range(0, 99);
		if (k < 40)
			return 13'($urandom_range(0, 15));
		if (k < 60)
			return 13'($urandom_range(BINS - 3, BINS));
		if (k < 70)
			return 13'($urandom_range(0, BINS));
		return 13'($urandom_range(0, 8191));
	endfunction

	function automatic req_t rand_request();
		req_t r;
		int   k;
		k              = $urandom_range(0, 99);
		r.req_type     = (k < 45) ? REQ_LOG : (k < 80) ? REQ_READ_COUNT :
			(k < 95) ? REQ_READ_TOTALS : REQ_RESERVED;
		r.is_alloc     = 1'($urandom_range(0, 1));
		r.is_realloc   = 1'($urandom_range(0, 1));
		r.is_zero_init = 1'($urandom_range(0, 1));
		r.succeeded    = 1'($urandom_range(0, 1));
		r.byte_count   = pick_size();
		r.read_table   = 3'($urandom_range(0, 7));
		r.read_bin     = pick_bin();
		return r;
	endfunction

	function automatic req_t make_req(req_type_t kind, logic [3:0] flags,
		logic [31:0] size, logic [2:0] tbl, logic [12:0] bin);
		req_t r;
		r.req_type     = kind;
		r.succeeded    = flags[3];
		r.is_realloc   = flags[2];
		r.is_alloc     = flags[1];
		r.is_zero_init = flags[0];
		r.byte_count   = size;
		r.read_table   = tbl;
		r.read_bin     = bin;
		return r;
	endfunction

	task automatic send_req(input req_t r, input int gap);
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_data  <= r;
		do @(posedge clk); while (!in_ready);
		sb.note_request(r);
	endtask

	task automatic wait_drain();
		while (sb.pending_reads.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic stop_and_drain();
		@(negedge clk);
		in_valid <= 1'b0;
		wait_drain();
	endtask

	task automatic write_profiling(input bit en);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= en;
		do @(posedge clk); while (!cfg_ready);
		sb.enabled = en;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_phase(input int n, input bit calm);
		int   counted;
		int   gap;
		req_t r;
		counted = 0;
		steady  = calm;
		while (counted < n) begin
			r   = rand_request();
			gap = (calm || $urandom_range(0, 1)) ? 0 : pick_gap();
			// now and then the sender waits for every read to come back
			if (!calm && $urandom_range(0, 99) < 2)
				stop_and_drain();
			send_req(r, gap);
			if (r.req_type != REQ_RESERVED && !(r.req_type == REQ_LOG && !sb.enabled))
				counted++;
		end
		stop_and_drain();
		steady = 1'b0;
	endtask

	// sink side: random back-pressure, or one long hold when asked
	initial begin : sink
		int stall;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (LONG_HOLD - 1) @(negedge clk);
			end else if (!steady && $urandom_range(0, 99) < 25) begin
				stall = pick_gap();
				out_ready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk)
		if (arst_n && out_valid && out_ready)
			sb.check_response(out_data);

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin : stimulus
		logic [31:0] sizes [8];
		int          t;
		cycles        = 0;
		steady        = 1'b0;
		long_hold_req = 1'b0;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		in_data       = '0;
		cfg_valid     = 1'b0;
		cfg_data      = 1'b0;
		sizes         = '{0, 1, BINS - 1, BINS, BINS + 1, 32'hFFFF_FFFF, 32'h8000_0000, 3};
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// profiling off: events dropped, totals read as invalid zeros
		write_profiling(1'b0);
		send_req(make_req(REQ_LOG, 4'b1011, 5, 0, 0), 0);
		send_req(make_req(REQ_READ_TOTALS, 4'b0000, 0, 0, 0), 0);
		send_req(make_req(REQ_READ_COUNT, 4'b0000, 0, 3'd7, 13'd5), 0);
		send_req(make_req(REQ_RESERVED, 4'b1111, 32'hFFFF_FFFF, 3'd7, 13'h1FFF), 0);
		stop_and_drain();

		// one event per table, zero-init set on frees too, size extremes
		write_profiling(1'b1);
		for (t = 0; t < 8; t++)
			send_req(make_req(REQ_LOG, {t[2:0], 1'b1}, sizes[t], 0, 0), 0);
		// back-to-back hits on one counter
		send_req(make_req(REQ_LOG, 4'b1110, 3, 0, 0), 0);
		send_req(make_req(REQ_LOG, 4'b1110, 3, 0, 0), 0);
		send_req(make_req(REQ_READ_COUNT, 4'b0000, 0, 3'd7, 13'd3), 0);
		send_req(make_req(REQ_READ_COUNT, 4'b0000, 0, 3'd5, 13'(BINS)), 0);
		send_req(make_req(REQ_READ_COUNT, 4'b0000, 0, 3'd4, 13'(BINS)), 0);
		send_req(make_req(REQ_READ_COUNT, 4'b0000, 0, 3'd5, 13'(BINS + 1)), 0);
		send_req(make_req(REQ_READ_COUNT, 4'b1111, 0, 3'd0, 13'h1FFF), 0);
		send_req(make_req(REQ_READ_COUNT, 4'b0000, 0, 3'd2, 13'(BINS - 1)), 0);
		send_req(make_req(REQ_READ_TOTALS, 4'b1111, 32'hFFFF_FFFF, 3'd7, 13'h1FFF), 0);
		send_req(make_req(REQ_RESERVED, 4'b0000, 0, 0, 0), 0);
		stop_and_drain();

		run_phase(300, 1'b0);

		// hold the output long enough for the core to back up its input
		long_hold_req = 1'b1;
		run_phase(120, 1'b1);

		write_profiling(1'b0);
		run_phase(100, 1'b0);

		write_profiling(1'b1);
		run_phase(250, 1'b1);
		run_phase(250, 1'b0);

		if (sb.pending_reads.size() != 0) begin
			$error("%0d reads never answered", sb.pending_reads.size());
			sb.errors++;
		end
		if (sb.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
